// ===== rtl/lqr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqr_pkg
// Types and constants shared by the linear queue with replace unit.
// ----------------------------------------------------------------------------
package lqr_pkg;

   localparam int LQR_DEPTH = 8;
   localparam int WORD_W    = 32;
   localparam int COUNT_W   = 4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_DELETE  = 2'd1,
      ACT_MODIFY  = 2'd2,
      ACT_DISPLAY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      action_type               action;
      logic signed [WORD_W-1:0] value;
      logic signed [WORD_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [WORD_W-1:0] data;
      logic [COUNT_W-1:0]       replaced_count;
      logic                     last;
   } rsp_type;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic              load;
      logic              shift;
      logic              modify;
      logic [WORD_W-1:0] match;
      logic [WORD_W-1:0] repl;
   } cell_ctrl_type;

endpackage

// ===== rtl/linear_queue_with_replace_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_queue_with_replace_unit
// Non-circular array queue with insert, delete, modify and display.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every result appears
// on rsp_item for one cycle with rsp_strobe high, and the receiver cannot
// stall it. Insert, and an overflow or empty error, leave the unit idle, and
// the next item may follow at once. Delete, modify and display load a token
// into the head cell; delete reads the head word, while modify and display
// pass the token along the chain of slot cells, one cell per cycle, display
// giving one result per word with last set on the tail word.
// ----------------------------------------------------------------------------
module linear_queue_with_replace_unit import lqr_pkg::*; #(
   parameter int DEPTH = LQR_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [IW-1:0]      head_ff, head_in, tail_ff, tail_in, idx_ff, idx_in;
   logic               empty_ff, empty_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in, cnt_sum;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   cell_ctrl_type      ctrl;
   logic               wr_en;
   logic [IW-1:0]      wr_idx;
   logic [DEPTH-1:0]   tok, hits;
   logic [WORD_W-1:0]  rd [DEPTH];
   logic [WORD_W-1:0]  sel_word;
   logic               hit_any, at_tail;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic tok_prev;
         if (g == 0) begin : g_first
            assign tok_prev = 1'b0;
         end else begin : g_rest
            assign tok_prev = tok[g-1];
         end
         lqr_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .is_head (head_ff == IW'(g)),
            .tok_in  (tok_prev),
            .wr_en   (wr_en && (wr_idx == IW'(g))),
            .wr_data (req_item.value),
            .tok_out (tok[g]),
            .hit     (hits[g]),
            .rd_data (rd[g])
         );
      end
   endgenerate

   always_comb begin
      sel_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_word = sel_word | rd[i];
      end
   end

   assign hit_any = |hits;
   assign at_tail = (idx_ff == tail_ff);
   assign cnt_sum = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + COUNT_W'(hit_any);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      idx_in        = idx_ff;
      empty_in      = empty_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '{status: ST_OK, data: '0, replaced_count: '0, last: 1'b1};
      wr_en         = 1'b0;
      wr_idx        = '0;
      ctrl.load     = 1'b0;
      ctrl.shift    = 1'b0;
      ctrl.modify   = (state_ff == S_SCAN) && (req_ff.action == ACT_MODIFY);
      ctrl.match    = req_ff.value;
      ctrl.repl     = req_ff.new_value;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.action == ACT_INSERT) begin
                  rsp_strobe_in = 1'b1;
                  if (empty_ff) begin
                     wr_en    = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                     empty_in = 1'b0;
                  end else if (tail_ff == LAST_SLOT) begin
                     rsp_in.status = ST_OVERFLOW;
                  end else begin
                     wr_en   = 1'b1;
                     wr_idx  = tail_ff + IW'(1);
                     tail_in = tail_ff + IW'(1);
                  end
               end else if (empty_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = ST_EMPTY;
               end else begin
                  ctrl.load = 1'b1;
                  idx_in    = head_ff;
                  cnt_in    = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            case (req_ff.action)
               ACT_DELETE: begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.data   = sel_word;
                  state_in      = S_IDLE;
                  if (head_ff >= tail_ff) begin
                     head_in  = '0;
                     tail_in  = '0;
                     empty_in = 1'b1;
                  end else begin
                     head_in = head_ff + IW'(1);
                  end
               end
               ACT_MODIFY: begin
                  cnt_in = cnt_sum;
                  if (at_tail) begin
                     rsp_strobe_in         = 1'b1;
                     rsp_in.status         = (cnt_sum != '0) ? ST_OK : ST_NOT_FOUND;
                     rsp_in.replaced_count = cnt_sum;
                     state_in              = S_IDLE;
                  end else begin
                     ctrl.shift = 1'b1;
                     idx_in     = idx_ff + IW'(1);
                  end
               end
               ACT_DISPLAY: begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.data   = sel_word;
                  rsp_in.last   = at_tail;
                  if (at_tail) begin
                     state_in = S_IDLE;
                  end else begin
                     ctrl.shift = 1'b1;
                     idx_in     = idx_ff + IW'(1);
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         empty_ff      <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         empty_ff      <= empty_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/lqr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqr_cell
// One queue slot: holds a word and the scan token passed along the chain.
// ----------------------------------------------------------------------------
module lqr_cell import lqr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic              is_head,
   input  logic              tok_in,
   input  logic              wr_en,
   input  logic [WORD_W-1:0] wr_data,
   output logic              tok_out,
   output logic              hit,
   output logic [WORD_W-1:0] rd_data
);

   logic              tok_ff, tok_in_sel;
   logic [WORD_W-1:0] word_ff, word_in;

   always_comb begin
      if (ctrl.load) begin
         tok_in_sel = is_head;
      end else if (ctrl.shift) begin
         tok_in_sel = tok_in;
      end else begin
         tok_in_sel = 1'b0;
      end
   end

   assign hit = tok_ff & ctrl.modify & (word_ff == ctrl.match);

   always_comb begin
      word_in = word_ff;
      if (wr_en) begin
         word_in = wr_data;
      end else if (hit) begin
         word_in = ctrl.repl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in_sel;
      end
      word_ff <= word_in;
   end

   assign tok_out = tok_ff;
   assign rd_data = tok_ff ? word_ff : '0;

endmodule
